// ===== design/flf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flf_pkg
// Shared types and constants for the framed log byte ring with frame drain.
// ----------------------------------------------------------------------------
package flf_pkg;

    localparam int DEF_RING_DEPTH = 512;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [1:0] MODE_START   = 2'd0;
    localparam logic [1:0] MODE_PAYLOAD = 2'd1;
    localparam logic [1:0] MODE_END     = 2'd2;
    localparam logic [1:0] MODE_XMIT    = 2'd3;

    localparam logic [1:0] REG_FRAME_ID = 2'd0;
    localparam logic [1:0] REG_MIN_FREE = 2'd1;
    localparam logic [1:0] REG_TRAILER  = 2'd2;

    localparam logic [10:0] FRAME_ID_RST = 11'h56C;
    localparam logic [1:0]  MIN_FREE_RST = 2'd2;
    localparam logic [15:0] TRAILER_RST  = 16'hBBCC;

    localparam logic [8:0]  FILL_MAX   = 9'd511;
    localparam logic [31:0] LOST_MAX   = 32'hFFFF_FFFF;
    localparam logic [3:0]  FRAME_BYTES = 4'd8;

    typedef enum logic [1:0] {
        OP_PUSH_ONE,
        OP_PUSH_TWO,
        OP_DRAIN
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  first_byte;
        logic [7:0]  second_byte;
        logic        drain_ok;
        logic [10:0] ident;
    } cmd_t;

    typedef struct packed {
        logic        frame_valid;
        logic [63:0] frame_data;
        logic [10:0] frame_ident;
        logic [3:0]  byte_count;
        logic [31:0] lost_bytes;
        logic [8:0]  fill_level;
    } res_t;

endpackage

// ===== design/framed_log_fifo_can_drain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_log_fifo_can_drain
// Byte ring for log records that drains into eight-byte bus frames.
//
//   channel   handshake            payload
//   item in   start / busy         mode, preamble, data_byte, free_mailboxes
//   result    done (one cycle)     frame_valid, frame_data, frame_ident,
//                                  byte_count, lost_bytes, fill_level
//   config    wr_en                wr_index, wr_data
//
// A drain reads one byte per cycle through the ring memory read port.
// busy rises only while the two-entry command queue is full.
// Reset clears pointers, fill and lost counters and restores the registers;
// the ring memory is not cleared. Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module framed_log_fifo_can_drain
    import flf_pkg::*;
#(
    parameter int RING_DEPTH = DEF_RING_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [15:0] wr_data,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [15:0] preamble,
    input  logic [7:0]  data_byte,
    input  logic [1:0]  free_mailboxes,
    output logic        done,
    output logic        frame_valid,
    output logic [63:0] frame_data,
    output logic [10:0] frame_ident,
    output logic [3:0]  byte_count,
    output logic [31:0] lost_bytes,
    output logic [8:0]  fill_level
);

    logic q_full;
    logic enq;
    cmd_t enq_cmd;
    logic head_valid;
    cmd_t head_cmd;
    logic cmd_pop;
    res_t res;

    flf_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .wr_en          (wr_en),
        .wr_index       (wr_index),
        .wr_data        (wr_data),
        .start          (start),
        .mode           (mode),
        .preamble       (preamble),
        .data_byte      (data_byte),
        .free_mailboxes (free_mailboxes),
        .q_full         (q_full),
        .busy           (busy),
        .enq            (enq),
        .cmd            (enq_cmd)
    );

    flf_cmd_q u_cmd_q (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (enq),
        .push_cmd   (enq_cmd),
        .pop        (cmd_pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    flf_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (head_valid),
        .cmd_in    (head_cmd),
        .cmd_pop   (cmd_pop),
        .done      (done),
        .res       (res)
    );

    assign frame_valid = res.frame_valid;
    assign frame_data  = res.frame_data;
    assign frame_ident = res.frame_ident;
    assign byte_count  = res.byte_count;
    assign lost_bytes  = res.lost_bytes;
    assign fill_level  = res.fill_level;

endmodule

// ===== design/flf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flf_front
// Configuration registers and item intake: turns each accepted item into a
// byte-push or drain command for the back end.
// ----------------------------------------------------------------------------
module flf_front
    import flf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [15:0] wr_data,
    input  logic        start,
    input  logic [1:0]  mode,
    input  logic [15:0] preamble,
    input  logic [7:0]  data_byte,
    input  logic [1:0]  free_mailboxes,
    input  logic        q_full,
    output logic        busy,
    output logic        enq,
    output cmd_t        cmd
);

    logic [10:0] frame_id_reg;
    logic [1:0]  min_free_reg;
    logic [15:0] trailer_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_id_reg <= FRAME_ID_RST;
            min_free_reg <= MIN_FREE_RST;
            trailer_reg  <= TRAILER_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_FRAME_ID: frame_id_reg <= wr_data[10:0];
                REG_MIN_FREE: min_free_reg <= wr_data[1:0];
                REG_TRAILER:  trailer_reg  <= wr_data;
                default:      ;
            endcase
        end
    end

    assign busy = q_full;
    assign enq  = start && !q_full;

    always_comb
    begin
        cmd.op          = OP_DRAIN;
        cmd.first_byte  = 8'd0;
        cmd.second_byte = 8'd0;
        cmd.drain_ok    = 1'b0;
        cmd.ident       = frame_id_reg;
        case (mode)
            MODE_START:
            begin
                cmd.op          = OP_PUSH_TWO;
                cmd.first_byte  = preamble[15:8];
                cmd.second_byte = preamble[7:0];
            end
            MODE_PAYLOAD:
            begin
                cmd.op         = OP_PUSH_ONE;
                cmd.first_byte = data_byte;
            end
            MODE_END:
            begin
                cmd.op          = OP_PUSH_TWO;
                cmd.first_byte  = trailer_reg[15:8];
                cmd.second_byte = trailer_reg[7:0];
            end
            default:
            begin
                cmd.op       = OP_DRAIN;
                cmd.drain_ok = (free_mailboxes >= min_free_reg);
            end
        endcase
    end

endmodule

// ===== design/flf_cmd_q.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flf_cmd_q
// Short command queue between intake and ring engine.
// ----------------------------------------------------------------------------
module flf_cmd_q
    import flf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output cmd_t head_cmd
);

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          entry_reg [QUEUE_DEPTH];
    logic [QW-1:0] wr_ptr_reg;
    logic [QW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full       = (count_reg == CW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

// ===== design/flf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flf_back
// Ring engine: byte ring memory, pointers, lost-byte counter and frame drain.
// ----------------------------------------------------------------------------
module flf_back
    import flf_pkg::*;
#(
    parameter int RING_DEPTH = DEF_RING_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  cmd_t cmd_in,
    output logic cmd_pop,
    output logic done,
    output res_t res
);

    localparam int PTR_W = $clog2(RING_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_PUSH  = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    logic [7:0]       byte_ring [RING_DEPTH];

    state_t           state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic             push_idx_reg, push_idx_next;
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [PTR_W-1:0] fill_reg, fill_next;
    logic [31:0]      lost_reg, lost_next;
    logic [63:0]      frame_reg, frame_next;
    logic [3:0]       issue_cnt_reg, issue_cnt_next;
    logic [2:0]       cap_idx_reg, cap_idx_next;
    logic             pend_reg, pend_next;
    logic             done_reg, done_next;
    res_t             res_reg, res_next;
    logic [7:0]       rd_data_reg;

    logic             mem_we;
    logic             mem_re;
    logic [7:0]       wr_byte;
    logic             ring_full;
    logic             issue;
    logic [8:0]       fill_sat;

    assign done = done_reg;
    assign res  = res_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            byte_ring[wp_reg] <= wr_byte;
        end
        if (mem_re)
        begin
            rd_data_reg <= byte_ring[rp_reg];
        end
    end

    assign wr_byte   = push_idx_reg ? cmd_reg.second_byte : cmd_reg.first_byte;
    assign ring_full = (fill_reg == PTR_W'(RING_DEPTH - 1));
    assign issue     = (issue_cnt_reg != FRAME_BYTES) && (fill_reg != '0);

    always_comb
    begin
        if (32'(fill_next) > 32'(FILL_MAX))
        begin
            fill_sat = FILL_MAX;
        end
        else
        begin
            fill_sat = 9'(fill_next);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        push_idx_next  = push_idx_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        fill_next      = fill_reg;
        lost_next      = lost_reg;
        frame_next     = frame_reg;
        issue_cnt_next = issue_cnt_reg;
        cap_idx_next   = cap_idx_reg;
        pend_next      = pend_reg;
        done_next      = 1'b0;
        cmd_pop        = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;

        res_next             = res_reg;
        res_next.frame_valid = 1'b0;
        res_next.frame_data  = 64'd0;
        res_next.frame_ident = 11'd0;
        res_next.byte_count  = 4'd0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop       = 1'b1;
                    cmd_next      = cmd_in;
                    push_idx_next = 1'b0;
                    case (cmd_in.op)
                        OP_PUSH_ONE, OP_PUSH_TWO:
                        begin
                            state_next = ST_PUSH;
                        end
                        OP_DRAIN:
                        begin
                            if (cmd_in.drain_ok && (fill_reg != '0))
                            begin
                                state_next     = ST_DRAIN;
                                frame_next     = 64'd0;
                                issue_cnt_next = 4'd0;
                                cap_idx_next   = 3'd0;
                                pend_next      = 1'b0;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_PUSH:
            begin
                if (ring_full)
                begin
                    if (lost_reg != LOST_MAX)
                    begin
                        lost_next = lost_reg + 32'd1;
                    end
                end
                else
                begin
                    mem_we    = 1'b1;
                    wp_next   = (wp_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_reg + PTR_W'(1);
                    fill_next = fill_reg + PTR_W'(1);
                end
                if ((cmd_reg.op != OP_PUSH_TWO) || push_idx_reg)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    push_idx_next = 1'b1;
                end
            end
            ST_DRAIN:
            begin
                // overlap the next read with capture of the last
                if (issue)
                begin
                    mem_re         = 1'b1;
                    rp_next        = (rp_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : rp_reg + PTR_W'(1);
                    fill_next      = fill_reg - PTR_W'(1);
                    issue_cnt_next = issue_cnt_reg + 4'd1;
                end
                pend_next = issue;
                if (pend_reg)
                begin
                    frame_next[{cap_idx_reg, 3'b000} +: 8] = rd_data_reg;
                    cap_idx_next = cap_idx_reg + 3'd1;
                end
                if (!issue && !pend_reg)
                begin
                    state_next           = ST_IDLE;
                    done_next            = 1'b1;
                    res_next.frame_valid = 1'b1;
                    res_next.frame_data  = frame_reg;
                    res_next.frame_ident = cmd_reg.ident;
                    res_next.byte_count  = issue_cnt_reg;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res_next.lost_bytes = lost_next;
        res_next.fill_level = fill_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            push_idx_reg  <= 1'b0;
            wp_reg        <= '0;
            rp_reg        <= '0;
            fill_reg      <= '0;
            lost_reg      <= '0;
            issue_cnt_reg <= '0;
            cap_idx_reg   <= '0;
            pend_reg      <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            push_idx_reg  <= push_idx_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            fill_reg      <= fill_next;
            lost_reg      <= lost_next;
            issue_cnt_reg <= issue_cnt_next;
            cap_idx_reg   <= cap_idx_next;
            pend_reg      <= pend_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        frame_reg <= frame_next;
        res_reg   <= res_next;
    end

endmodule

// ===== dv/framed_log_fifo_can_drain_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_log_fifo_can_drain_test
// Self-checking bench for the framed log byte ring. A queue of log words
// (record starts, payload bytes, record ends and transmit opportunities)
// feeds a clocked driver; every accepted word runs through a local ring
// model and the expected report is queued. A clocked monitor compares
// each done strobe against the oldest expected report. Phases change the
// registers, the traffic mix and the sender idle rate; the ring is driven
// into overflow and drained back to empty.
// ----------------------------------------------------------------------------
module framed_log_fifo_can_drain_test;
    import flf_pkg::*;

    localparam logic [1:0] REG_NONE = 2'd3;

    typedef struct {
        logic [1:0]  mode;
        logic [15:0] preamble;
        logic [7:0]  data_byte;
        logic [1:0]  free_mailboxes;
    } log_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        wr_en = 1'b0;
    logic [1:0]  wr_index = '0;
    logic [15:0] wr_data = '0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  mode = '0;
    logic [15:0] preamble = '0;
    logic [7:0]  data_byte = '0;
    logic [1:0]  free_mailboxes = '0;
    logic        done;
    logic        frame_valid;
    logic [63:0] frame_data;
    logic [10:0] frame_ident;
    logic [3:0]  byte_count;
    logic [31:0] lost_bytes;
    logic [8:0]  fill_level;

    log_word_t log_words[$];
    log_word_t cur_word;
    res_t      due_reports[$];
    int        idle_pct = 0;
    int        mismatches = 0;

    logic [7:0]  ring_mem [0:DEF_RING_DEPTH-1];
    logic [8:0]  head = '0;
    logic [8:0]  tail = '0;
    logic [31:0] drops = '0;
    logic [10:0] cfg_ident = FRAME_ID_RST;
    logic [1:0]  cfg_min_free = MIN_FREE_RST;
    logic [15:0] cfg_trailer = TRAILER_RST;

    framed_log_fifo_can_drain i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .wr_en          (wr_en),
        .wr_index       (wr_index),
        .wr_data        (wr_data),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .preamble       (preamble),
        .data_byte      (data_byte),
        .free_mailboxes (free_mailboxes),
        .done           (done),
        .frame_valid    (frame_valid),
        .frame_data     (frame_data),
        .frame_ident    (frame_ident),
        .byte_count     (byte_count),
        .lost_bytes     (lost_bytes),
        .fill_level     (fill_level)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic push_ring(input logic [7:0] b);
        logic [8:0] nxt;
        nxt = tail + 9'd1;
        if (nxt == head)
        begin
            if (drops != LOST_MAX)
                drops = drops + 32'd1;
        end
        else
        begin
            ring_mem[tail] = b;
            tail = nxt;
        end
    endtask

    task automatic advance_ring(input log_word_t w, output res_t r);
        int n;
        r = '0;
        case (w.mode)
            MODE_START:
            begin
                push_ring(w.preamble[15:8]);
                push_ring(w.preamble[7:0]);
            end
            MODE_PAYLOAD:
                push_ring(w.data_byte);
            MODE_END:
            begin
                push_ring(cfg_trailer[15:8]);
                push_ring(cfg_trailer[7:0]);
            end
            default:
            begin
                if (head != tail && w.free_mailboxes >= cfg_min_free)
                begin
                    r.frame_valid = 1'b1;
                    r.frame_ident = cfg_ident;
                    n = 0;
                    while (n < 8 && head != tail)
                    begin
                        r.frame_data[8*n +: 8] = ring_mem[head];
                        head = head + 9'd1;
                        n++;
                    end
                    r.byte_count = 4'(n);
                end
            end
        endcase
        r.lost_bytes = drops;
        r.fill_level = tail - head;
    endtask

    function automatic log_word_t make_word(input logic [1:0] m, input logic [15:0] pre,
                                            input logic [7:0] data, input logic [1:0] mbox);
        log_word_t w;
        w.mode = m;
        w.preamble = pre;
        w.data_byte = data;
        w.free_mailboxes = mbox;
        return w;
    endfunction

    function automatic log_word_t rand_word(input logic [1:0] m);
        return make_word(m, 16'($urandom), 8'($urandom), 2'($urandom_range(0, 3)));
    endfunction

    task automatic sprinkle_xmit(input int xmit_pct, inout int count);
        while ($urandom_range(99) < xmit_pct)
        begin
            log_words.push_back(rand_word(MODE_XMIT));
            count++;
        end
    endtask

    task automatic queue_phase(input int n, input int xmit_pct);
        int count;
        int len;
        count = 0;
        while (count < n)
        begin
            if ($urandom_range(99) < 10)
            begin
                log_words.push_back(rand_word(2'($urandom_range(0, 3))));
                count++;
            end
            else
            begin
                len = $urandom_range(0, 12);
                log_words.push_back(rand_word(MODE_START));
                count++;
                sprinkle_xmit(xmit_pct, count);
                repeat (len)
                begin
                    log_words.push_back(rand_word(MODE_PAYLOAD));
                    count++;
                    sprinkle_xmit(xmit_pct, count);
                end
                log_words.push_back(rand_word(MODE_END));
                count++;
            end
            sprinkle_xmit(xmit_pct, count);
        end
    endtask

    task automatic settle();
        @(negedge clk);
        while (log_words.size() != 0 || start || due_reports.size() != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= value;
        @(posedge clk);
        wr_en <= 1'b0;
        case (idx)
            REG_FRAME_ID: cfg_ident = value[10:0];
            REG_MIN_FREE: cfg_min_free = value[1:0];
            REG_TRAILER:  cfg_trailer = value;
            default:      ;
        endcase
    endtask

    task automatic configure(input logic [10:0] id, input logic [1:0] min_free,
                             input logic [15:0] trailer);
        write_reg(REG_FRAME_ID, {5'b0, id});
        write_reg(REG_MIN_FREE, {14'b0, min_free});
        write_reg(REG_TRAILER, trailer);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_words
        res_t r;
        logic free_slot;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                advance_ring(cur_word, r);
                due_reports.push_back(r);
            end
            free_slot = !start || !busy;
            if (free_slot && log_words.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                cur_word = log_words.pop_front();
                start <= 1'b1;
                mode <= cur_word.mode;
                preamble <= cur_word.preamble;
                data_byte <= cur_word.data_byte;
                free_mailboxes <= cur_word.free_mailboxes;
            end
            else if (free_slot)
            begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : check_frames
        res_t seen;
        res_t want;
        if (rst_n && done)
        begin
            seen = {frame_valid, frame_data, frame_ident, byte_count, lost_bytes, fill_level};
            if (due_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: valid %0b data %h ident %h ",
                             seen.frame_valid, seen.frame_data, seen.frame_ident,
                             "count %0d lost %0d fill %0d",
                             seen.byte_count, seen.lost_bytes, seen.fill_level);
            end
            else
            begin
                want = due_reports.pop_front();
                if (seen !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch (expected/actual): valid %0b/%0b data %h/%h ",
                                 want.frame_valid, seen.frame_valid,
                                 want.frame_data, seen.frame_data,
                                 "ident %h/%h count %0d/%0d lost %0d/%0d fill %0d/%0d",
                                 want.frame_ident, seen.frame_ident,
                                 want.byte_count, seen.byte_count,
                                 want.lost_bytes, seen.lost_bytes,
                                 want.fill_level, seen.fill_level);
                end
            end
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        log_words.push_back(make_word(MODE_XMIT, 16'hFFFF, 8'hFF, 2'd3));
        log_words.push_back(make_word(MODE_START, 16'h0000, 8'hFF, 2'd3));
        log_words.push_back(make_word(MODE_START, 16'hFFFF, 8'h00, 2'd0));
        log_words.push_back(make_word(MODE_PAYLOAD, 16'hFFFF, 8'h00, 2'd3));
        log_words.push_back(make_word(MODE_PAYLOAD, 16'h0000, 8'hFF, 2'd0));
        log_words.push_back(make_word(MODE_END, 16'h1234, 8'h5A, 2'd1));
        log_words.push_back(make_word(MODE_PAYLOAD, 16'h0000, 8'h5A, 2'd2));
        log_words.push_back(make_word(MODE_XMIT, 16'h0000, 8'h00, 2'd0));
        log_words.push_back(make_word(MODE_XMIT, 16'h0000, 8'h00, 2'd1));
        log_words.push_back(make_word(MODE_XMIT, 16'h0000, 8'h00, 2'd2));
        log_words.push_back(make_word(MODE_XMIT, 16'hFFFF, 8'hFF, 2'd3));
        log_words.push_back(make_word(MODE_XMIT, 16'hFFFF, 8'hFF, 2'd3));
        log_words.push_back(make_word(MODE_PAYLOAD, 16'h0000, 8'h80, 2'd0));
        log_words.push_back(make_word(MODE_PAYLOAD, 16'h0000, 8'h01, 2'd0));
        log_words.push_back(make_word(MODE_START, 16'h8001, 8'h00, 2'd0));
        log_words.push_back(make_word(MODE_END, 16'h0000, 8'h00, 2'd0));
        log_words.push_back(make_word(MODE_XMIT, 16'h0000, 8'h00, 2'd3));
        log_words.push_back(make_word(MODE_XMIT, 16'h0000, 8'h00, 2'd2));
        settle();

        configure(11'd0, 2'd0, 16'h0000);
        idle_pct = 0;
        queue_phase(300, 30);
        settle();

        configure(11'h7FF, 2'd3, 16'hFFFF);
        write_reg(REG_NONE, 16'h0001);
        idle_pct = 48;
        queue_phase(600, 4);
        settle();

        configure(11'h2AA, 2'd1, 16'hA55A);
        idle_pct = 34;
        queue_phase(400, 60);
        settle();

        configure(11'h555, 2'd2, 16'h1234);
        idle_pct = 0;
        queue_phase(350, 20);
        settle();

        configure(11'h0F0, 2'd0, 16'h00FF);
        idle_pct = 48;
        queue_phase(280, 35);
        settle();

        if (mismatches == 0 && due_reports.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
